### hw/rtl/sha256_message_hasher_defines.svh
// Assertion macros shared by the SHA-256 hasher RTL.
// Depends on nothing; included by the top level.
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH
// clocked implication check, disabled in reset
`define SHA_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// next-cycle implication check, disabled in reset
`define SHA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`endif

### hw/rtl/sha_pkg.sv
// Package for the SHA-256 hasher: round constants, initial hash, state codes.
// Depends on nothing.
package sha_pkg;
   localparam int BlockBytes = 64;
   localparam int BlockWords = 16;
   localparam int Rounds     = 64;
   localparam int HashWords  = 8;

   typedef enum logic [2:0] {
      ST_IDLE, ST_BYTES, ST_PAD, ST_ROUND, ST_FOLD, ST_EMIT
   } state_type;

   typedef struct packed {
      logic       start;
      logic       fold;
      logic       reinit;
      logic [5:0] round;
   } core_ctl_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [0:63];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] h [0:7];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[i];
   endfunction
endpackage

### hw/rtl/sha_core.sv
// SHA-256 round engine: message schedule window, working variables, chain.
// Depends on sha_pkg.
module sha_core import sha_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  core_ctl_type        ctl,
   input  logic [BlockWords*32-1:0] block_words,
   input  logic [2:0]          rd_index,
   output logic [31:0]         rd_word
);
   logic [31:0] w_ff [0:15];
   logic [31:0] w_in [0:15];
   logic [31:0] v_ff [0:7];
   logic [31:0] v_in [0:7];
   logic [31:0] h_ff [0:7];
   logic [31:0] h_in [0:7];
   logic [31:0] s0, s1, big0, big1, ch, maj, t1, t2, wnew;

   // one round: schedule word and compression step
   always_comb begin
      s0   = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]} ^ (w_ff[1] >> 3);
      s1   = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
             ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      big1 = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
             ^ {v_ff[4][24:0], v_ff[4][31:25]};
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + round_k(ctl.round) + w_ff[0];
      big0 = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
             ^ {v_ff[0][21:0], v_ff[0][31:22]};
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;
      for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
      w_in[15] = wnew;
      v_in[0] = t1 + t2;
      v_in[1] = v_ff[0];
      v_in[2] = v_ff[1];
      v_in[3] = v_ff[2];
      v_in[4] = v_ff[3] + t1;
      v_in[5] = v_ff[4];
      v_in[6] = v_ff[5];
      v_in[7] = v_ff[6];
      for (int i = 0; i < 8; i++) h_in[i] = h_ff[i];
      if (ctl.start) begin
         for (int i = 0; i < 16; i++) w_in[i] = block_words[(15-i)*32 +: 32];
         for (int i = 0; i < 8; i++) v_in[i] = h_ff[i];
      end
      if (ctl.fold)
         for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
      if (ctl.reinit)
         for (int i = 0; i < 8; i++) h_in[i] = init_hash(3'(i));
   end

   // hold schedule and working state, chain resets to initial hash
   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      if (reset) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else begin
         h_ff <= h_in;
      end
   end

   assign rd_word = h_ff[rd_index];
endmodule

### hw/rtl/sha256_message_hasher.sv
// SHA-256 hasher, one beat at a time. A beat is accepted, its bytes are pushed one per
// cycle and it closes; a full block pauses the pushes for the rounds and a fold in the
// shared round engine. A last beat then pads one byte per cycle (64 - fill bytes, plus a
// whole block when the length does not fit), likewise pausing, and emits 8 digest beats.
// Synchronous active-high reset loads the initial hash and clears counters.
`include "sha256_message_hasher_defines.svh"
module sha256_message_hasher import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_final_word
);
   state_type    state_ff, state_in;
   logic [31:0]  data_ff, data_in;
   logic [2:0]   left_ff, left_in;
   logic         last_ff, last_in;
   logic [63:0]  bits_ff, bits_in, len_ff, len_in;
   logic [5:0]   fill_ff, fill_in;
   logic [6:0]   pad_ff, pad_in;      // padding bytes pushed so far
   logic         room_ff, room_in;    // length bytes go into this block
   logic [5:0]   round_ff, round_in;
   logic [2:0]   idx_ff, idx_in;
   logic [8*(BlockBytes-1)-1:0] blk_ff, blk_in;
   logic [BlockWords*32-1:0] block_words;
   logic         push;
   logic [7:0]   push_byte;
   logic [2:0]   cnt;
   core_ctl_type ctl;
   logic [31:0]  hash_word;

   assign cnt = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;

   // next state, byte pushes and handshakes
   always_comb begin
      state_in = state_ff;
      data_in = data_ff; left_in = left_ff; last_in = last_ff;
      bits_in = bits_ff; len_in = len_ff; fill_in = fill_ff; pad_in = pad_ff;
      room_in = room_ff;
      round_in = round_ff; idx_in = idx_ff;
      push = 1'b0; push_byte = data_ff[31:24];
      ctl = '0; ctl.round = round_ff;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            data_in = req_data_word; left_in = cnt; last_in = req_is_last;
            bits_in = bits_ff + {58'd0, cnt, 3'd0};
            pad_in = 7'd0;
            state_in = ST_BYTES;
         end
         ST_BYTES: begin
            if (left_ff != 3'd0) begin
               push = 1'b1;
               data_in = {data_ff[23:0], 8'd0};
               left_in = left_ff - 3'd1;
            end else if (last_ff) begin
               len_in = bits_ff; pad_in = 7'd0; state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            push = 1'b1;
            pad_in = pad_ff + 7'd1;
            if (pad_ff == 7'd0) begin
               push_byte = 8'h80;
               room_in = (fill_ff < 6'd56);
            end else if (room_ff && fill_ff >= 6'd56) begin
               push_byte = len_ff[{~fill_ff[2:0], 3'b111} -: 8];
            end else begin
               push_byte = 8'h00;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            ctl.fold = 1'b1;
            // resume bytes, continue padding, or emit once the length block is folded
            if (left_ff != 3'd0 || pad_ff == 7'd0) begin
               state_in = ST_BYTES;
            end else if (pad_ff >= 7'd9) begin
               state_in = ST_EMIT; idx_in = 3'd0;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_EMIT: if (!rsp_stall) begin
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd7) begin
               ctl.reinit = 1'b1; bits_in = '0; fill_in = '0;
               last_in = 1'b0; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // after each pushed byte, start compression on a full block
      if (push) begin
         fill_in = fill_ff + 6'd1;
         if (fill_ff == 6'd63) begin
            ctl.start = 1'b1; round_in = 6'd0; state_in = ST_ROUND;
            if (state_ff == ST_PAD) room_in = 1'b1;
         end
      end
   end

   // shift each pushed byte into the block register
   assign blk_in = push ? {blk_ff[8*(BlockBytes-2)-1:0], push_byte} : blk_ff;

   // state, counters and block bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bits_ff <= '0; fill_ff <= '0; last_ff <= 1'b0; left_ff <= '0;
         pad_ff <= '0; room_ff <= 1'b0; round_ff <= '0; idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         bits_ff <= bits_in; fill_ff <= fill_in; last_ff <= last_in; left_ff <= left_in;
         pad_ff <= pad_in; room_ff <= room_in; round_ff <= round_in; idx_ff <= idx_in;
      end
      data_ff <= data_in;
      len_ff <= len_in;
      blk_ff <= blk_in;
   end

   // the 64th byte joins the 63 held bytes as the block is started
   assign block_words = {blk_ff, push_byte};

   sha_core u_core (
      .clock(clock), .reset(reset), .ctl(ctl), .block_words(block_words),
      .rd_index(idx_ff), .rd_word(hash_word)
   );

   assign rsp_digest_word = hash_word;
   assign rsp_word_index  = idx_ff;
   assign rsp_final_word  = (idx_ff == 3'd7);

   `SHA_ASSERT_IMP(a_no_rsp_idle, clock, reset, state_ff == ST_IDLE, !rsp_valid,
      "digest beat outside emit")
   `SHA_ASSERT_IMP(a_stall_busy, clock, reset, rsp_valid, req_stall,
      "request taken while emitting")
   `SHA_ASSERT_NEXT(a_round_go, clock, reset, ctl.start, state_ff == ST_ROUND && round_ff == 6'd0,
      "compression did not begin")
endmodule

### tb/sv/sha256_digest_checker.sv
// Checker for the SHA-256 message hasher: watches request and digest beats,
// computes the expected digest words itself and compares. Depends on sha_pkg.
module sha256_digest_checker import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_is_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_final_word,
   output int          fail_count,
   output int          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        final_flag;
   } digest_beat_t;

   logic [31:0]  hash_state [0:7];
   logic [63:0]  bit_length;
   logic [7:0]   msg_block [0:63];
   int           fill_bytes;
   digest_beat_t digest_queue [$];

   assign pending_words = digest_queue.size();

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // fold the buffered block into the hash state
   task automatic fold_block();
      logic [31:0] w [0:63];
      logic [31:0] v [0:7];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic append_byte(input logic [7:0] b);
      msg_block[fill_bytes] = b;
      fill_bytes++;
      if (fill_bytes == BlockBytes) begin
         fold_block();
         fill_bytes = 0;
      end
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) hash_state[i] = init_hash(i[2:0]);
      bit_length = '0;
      fill_bytes = 0;
   endtask

   // absorb one accepted beat; on the last one pad and queue the digest
   task automatic absorb_beat(input logic [31:0] data, input logic [2:0] cnt,
                              input logic last);
      int n;
      logic [63:0] len;
      n = (cnt > 3'd4) ? 4 : int'(cnt);
      bit_length += 64'(n * 8);
      for (int i = 0; i < n; i++) append_byte(data[31 - 8*i -: 8]);
      if (last) begin
         len = bit_length;
         append_byte(8'h80);
         while (fill_bytes != 56) append_byte(8'h00);
         for (int i = 0; i < 8; i++) append_byte(len[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++)
            digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
         restart_message();
      end
   endtask

   initial begin
      fail_count = 0;
      restart_message();
   end

   // watch both channels
   always @(posedge clock) begin
      digest_beat_t exp_beat;
      if (reset) begin
         restart_message();
      end else begin
         if (req_valid && !req_stall)
            absorb_beat(req_data_word, req_byte_count, req_is_last);
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               $error("unexpected digest beat word=%h", rsp_digest_word);
               fail_count++;
            end else begin
               exp_beat = digest_queue.pop_front();
               if (rsp_digest_word !== exp_beat.word) begin
                  $error("digest_word expected %h actual %h", exp_beat.word, rsp_digest_word);
                  fail_count++;
               end
               if (rsp_word_index !== exp_beat.index) begin
                  $error("word_index expected %0d actual %0d", exp_beat.index, rsp_word_index);
                  fail_count++;
               end
               if (rsp_final_word !== exp_beat.final_flag) begin
                  $error("final_word expected %0d actual %0d", exp_beat.final_flag,
                         rsp_final_word);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

### tb/sv/tb.sv
// Top of the SHA-256 hasher testbench: clock, reset, message stimulus and verdict.
// Depends on sha_pkg, sha256_message_hasher and sha256_digest_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_final_word;
   int          fail_count;
   int          pending_words;
   bit          quiet_phase = 1'b0;
   bit          hold_off = 1'b0;
   int          beats_sent = 0;

   sha256_message_hasher u_top (.*);
   sha256_digest_checker u_check (.*);

   initial forever #5 clock = ~clock;

   // send one beat, with an occasional idle burst before it
   task automatic send_beat(input logic [31:0] data, input logic [2:0] cnt,
                            input logic last);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= data;
      req_byte_count <= cnt;
      req_is_last    <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // one message of random beats; most byte counts are full words
   task automatic send_message(input int beats);
      logic [2:0] cnt;
      for (int i = 0; i < beats; i++) begin
         cnt = ($urandom_range(0, 3) != 0) ? 3'd4 : 3'($urandom_range(0, 7));
         send_beat($urandom, cnt, i == beats - 1);
      end
   endtask

   // receiver stalls in bursts, plus one long hold-off
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if (quiet_phase) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   initial begin
      @(posedge clock);
      while (beats_sent < 60) @(posedge clock);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // empty message, then extremes of the fields
      send_beat(32'h0, 3'd0, 1'b1);
      send_beat(32'h61626300, 3'd3, 1'b1);
      send_beat(32'hffffffff, 3'd7, 1'b0);
      send_beat(32'h00000000, 3'd5, 1'b0);
      send_beat(32'hdeadbeef, 3'd6, 1'b0);
      send_beat(32'h12345678, 3'd1, 1'b0);
      send_beat(32'h9abcdef0, 3'd2, 1'b0);
      send_beat(32'h55aa55aa, 3'd0, 1'b1);
      // exactly 55 and 56 bytes: padding fits, then spills into a second block
      for (int i = 0; i < 13; i++) send_beat($urandom, 3'd4, 1'b0);
      send_beat($urandom, 3'd3, 1'b1);
      for (int i = 0; i < 14; i++) send_beat($urandom, 3'd4, i == 13);
      // random messages, mostly short, a few long
      while (beats_sent < 330) begin
         if ($urandom_range(0, 7) == 0) send_message($urandom_range(17, 40));
         else send_message($urandom_range(1, 12));
      end
      quiet_phase = 1'b1;
      while (beats_sent < 375) send_message($urandom_range(1, 10));
      req_valid <= 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) $display("** sha256_message_hasher: PASSED **");
      else $display("** sha256_message_hasher: FAILED **");
      $finish;
   end

   initial begin
      #5ms;
      $display("** sha256_message_hasher: FAILED **");
      $finish;
   end
endmodule
